// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; compiled out under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define DMES_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion violated");
// expression must never be true outside reset
`define DMES_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition");
`else
`define DMES_ASSERT(name, clk, rst, prop)
`define DMES_NEVER(name, clk, rst, expr)
`endif

`endif

// ===== hdl/dmes_pkg.sv =====
// ---------------------------------------------------------------------------
// dmes_pkg
// Types, constants and helper functions of the motor drive / encoder block.
// ---------------------------------------------------------------------------
package dmes_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int DIFF_LIMIT  = 2 ** 20;
   localparam int DIFF_W      = 22;          // holds +-DIFF_LIMIT
   localparam int EXT_W       = (COUNT_WIDTH > DIFF_W) ? COUNT_WIDTH : DIFF_W;
   localparam int VOLT_W      = 16;
   localparam int NUM_W       = VOLT_W + 10; // v*255 + 1536, signed
   localparam int DUTY_W      = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int OFFSET_W    = DIFF_W + 9;  // 9-bit signed gain times diff
   localparam int QUOT_IN_W   = 13;          // |num| >> 10
   localparam int QUOT_W      = 12;          // floor(x / 3)
   localparam int BASE_W      = QUOT_W + 1;
   localparam int DEMAND_W    = OFFSET_W + 1;
   localparam int RECIP3      = 43691;       // ceil(2^17 / 3)
   localparam int RECIP3_SH   = 17;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_GAIN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_DEADBAND  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_DEADBAND = 2'd2;

   typedef enum logic {
      MODE_ENCODER = 1'b0,
      MODE_DRIVE   = 1'b1
   } mode_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] offset_gain;
      logic [CSR_DATA_W-1:0] left_deadband;
      logic [CSR_DATA_W-1:0] right_deadband;
   } cfg_type;

   // one drive request as queued between front and back
   typedef struct packed {
      logic signed [VOLT_W-1:0] voltage;
      logic signed [DIFF_W-1:0] diff;
   } cmd_type;

   typedef struct packed {
      logic              reverse;
      logic [DUTY_W-1:0] duty;
   } motor_type;

   // direction and clamped duty for one motor
   function automatic motor_type motor_out(logic signed [DEMAND_W-1:0] demand,
                                           logic [DUTY_W-1:0] deadband);
      logic signed [DEMAND_W:0] mag;
      motor_type                res;
      if (demand > 0) begin
         res.reverse = 1'b0;
         mag = (DEMAND_W+1)'(demand) + $signed({1'b0, deadband});
      end else begin
         res.reverse = 1'b1;
         mag = $signed({1'b0, deadband}) - (DEMAND_W+1)'(demand);
      end
      if (mag > 255) begin
         res.duty = {DUTY_W{1'b1}};
      end else begin
         res.duty = mag[DUTY_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== hdl/dmes_queue.sv =====
// ---------------------------------------------------------------------------
// dmes_queue
// Short FIFO of drive requests between the front and back sections.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dmes_queue
   import dmes_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   cmd_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `DMES_ASSERT(a_count_bound, clock, reset, count_ff <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
   `DMES_NEVER(a_pop_empty, clock, reset, pop && empty)
   `DMES_NEVER(a_push_full, clock, reset, push && full)

endmodule

// ===== hdl/dmes_front.sv =====
// ---------------------------------------------------------------------------
// dmes_front
// Accepts requests: encoder samples update the counts, drive requests are
// queued with a snapshot of the saturated count difference.
// ---------------------------------------------------------------------------
module dmes_front
   import dmes_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_mode,
   input  logic                     req_left_a,
   input  logic                     req_left_b,
   input  logic                     req_right_a,
   input  logic                     req_right_b,
   input  logic signed [VOLT_W-1:0] req_voltage,
   input  logic                     queue_full,
   output logic                     push,
   output cmd_type                  push_data
);

   logic [COUNT_WIDTH-1:0] left_count_ff, left_count_in;
   logic [COUNT_WIDTH-1:0] right_count_ff, right_count_in;
   logic                   left_a_last_ff, left_a_last_in;
   logic                   right_a_last_ff, right_a_last_in;
   logic                   accept;
   logic                   is_drive;
   logic [COUNT_WIDTH-1:0] raw_diff;
   logic signed [EXT_W-1:0] ext_diff;
   logic signed [EXT_W-1:0] sat_diff;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign is_drive  = (req_mode == MODE_DRIVE);
   assign push      = accept && is_drive;

   // wrapped difference, read signed, clipped to +-DIFF_LIMIT
   always_comb begin
      raw_diff = right_count_ff - left_count_ff;
      ext_diff = EXT_W'(signed'(raw_diff));
      if (ext_diff > EXT_W'(DIFF_LIMIT)) begin
         sat_diff = EXT_W'(DIFF_LIMIT);
      end else if (ext_diff < -EXT_W'(DIFF_LIMIT)) begin
         sat_diff = -EXT_W'(DIFF_LIMIT);
      end else begin
         sat_diff = ext_diff;
      end
      push_data.voltage = req_voltage;
      push_data.diff    = DIFF_W'(sat_diff);
   end

   always_comb begin
      left_count_in   = left_count_ff;
      right_count_in  = right_count_ff;
      left_a_last_in  = left_a_last_ff;
      right_a_last_in = right_a_last_ff;
      if (accept && !is_drive) begin
         if (req_left_a != left_a_last_ff) begin
            left_a_last_in = req_left_a;
            left_count_in  = (req_left_a != req_left_b) ?
                             left_count_ff - COUNT_WIDTH'(1) :
                             left_count_ff + COUNT_WIDTH'(1);
         end
         if (req_right_a != right_a_last_ff) begin
            right_a_last_in = req_right_a;
            right_count_in  = (req_right_a != req_right_b) ?
                              right_count_ff + COUNT_WIDTH'(1) :
                              right_count_ff - COUNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_count_ff   <= '0;
         right_count_ff  <= '0;
         left_a_last_ff  <= 1'b0;
         right_a_last_ff <= 1'b0;
      end else begin
         left_count_ff   <= left_count_in;
         right_count_ff  <= right_count_in;
         left_a_last_ff  <= left_a_last_in;
         right_a_last_ff <= right_a_last_in;
      end
   end

endmodule

// ===== hdl/dmes_back.sv =====
// ---------------------------------------------------------------------------
// dmes_back
// Three-stage drive pipeline: scale and offset product, divide by three,
// then demand, deadband and clamp into the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dmes_back
   import dmes_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  cmd_type           head,
   input  logic              queue_empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_left_reverse,
   output logic [DUTY_W-1:0] rsp_left_duty,
   output logic              rsp_right_reverse,
   output logic [DUTY_W-1:0] rsp_right_duty
);

   logic                        s1_valid_ff, s1_valid_in;
   logic                        s2_valid_ff, s2_valid_in;
   logic                        out_valid_ff, out_valid_in;
   logic                        adv1, adv2, adv_out;

   logic [QUOT_IN_W-1:0]        s1_x_ff;
   logic                        s1_neg_ff;
   logic signed [OFFSET_W-1:0]  s1_off_ff;
   logic signed [BASE_W-1:0]    s2_base_ff;
   logic signed [OFFSET_W-1:0]  s2_off_ff;
   motor_type                   left_ff, right_ff;

   logic signed [NUM_W-1:0]     num;
   logic [NUM_W-1:0]            num_mag;
   logic signed [OFFSET_W-1:0]  offset;
   logic [QUOT_IN_W+RECIP3_SH+3:0] recip_prod;
   logic [QUOT_W-1:0]           quot;
   logic signed [BASE_W-1:0]    base;
   logic signed [DEMAND_W-1:0]  demand_left, demand_right;

   assign adv_out = !out_valid_ff || !rsp_stall;
   assign adv2    = !s2_valid_ff || adv_out;
   assign adv1    = !s1_valid_ff || adv2;
   assign pop     = !queue_empty && adv1;

   assign s1_valid_in  = adv1    ? pop          : s1_valid_ff;
   assign s2_valid_in  = adv2    ? s1_valid_ff  : s2_valid_ff;
   assign out_valid_in = adv_out ? s2_valid_ff  : out_valid_ff;

   // stage 1: num = v*255 + 1536, |num| / 1024; gain times count difference
   always_comb begin
      num     = (NUM_W'(head.voltage) <<< 8) - NUM_W'(head.voltage) + NUM_W'(1536);
      num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      offset  = OFFSET_W'($signed({1'b0, cfg.offset_gain})) * OFFSET_W'(head.diff);
   end

   // stage 2: floor(x / 3) by reciprocal, restore sign (trunc toward zero)
   always_comb begin
      recip_prod = (QUOT_IN_W+RECIP3_SH+4)'(s1_x_ff) * (QUOT_IN_W+RECIP3_SH+4)'(RECIP3);
      quot       = QUOT_W'(recip_prod >> RECIP3_SH);
      base       = s1_neg_ff ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
   end

   // stage 3: per-motor demand
   always_comb begin
      demand_left  = DEMAND_W'(s2_base_ff) + DEMAND_W'(s2_off_ff);
      demand_right = DEMAND_W'(s2_base_ff) - DEMAND_W'(s2_off_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_x_ff   <= num_mag[QUOT_IN_W+9:10];
         s1_neg_ff <= num[NUM_W-1];
         s1_off_ff <= offset;
      end
      if (adv2) begin
         s2_base_ff <= base;
         s2_off_ff  <= s1_off_ff;
      end
      if (adv_out) begin
         left_ff  <= motor_out(demand_left, cfg.left_deadband);
         right_ff <= motor_out(demand_right, cfg.right_deadband);
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_left_reverse  = left_ff.reverse;
   assign rsp_left_duty     = left_ff.duty;
   assign rsp_right_reverse = right_ff.reverse;
   assign rsp_right_duty    = right_ff.duty;

   // forward drive always means a positive demand, so duty is never zero
   `DMES_NEVER(a_left_fwd_duty, clock, reset, out_valid_ff && !left_ff.reverse && left_ff.duty == '0)
   `DMES_NEVER(a_right_fwd_duty, clock, reset, out_valid_ff && !right_ff.reverse && right_ff.duty == '0)
   `DMES_ASSERT(a_s2_hold, clock, reset, s2_valid_ff && !adv_out |=> s2_valid_ff && $stable(s2_base_ff))

endmodule

// ===== hdl/differential_motor_drive_encoder_sync_unit.sv =====
// ---------------------------------------------------------------------------
// differential_motor_drive_encoder_sync_unit
// Differential motor drive with encoder-count synchronization.
// ---------------------------------------------------------------------------
// Usage:
//   req_* channel (valid/stall): one request per cycle. req_mode selects an
//     encoder pin sample (updates the wheel counts, no response) or a drive
//     request (signed voltage, 1/256 V, yields exactly one response).
//   rsp_* channel (valid/stall): direction and PWM duty for both motors,
//     in request order.
//   csr_* port: write-only registers offset_gain, left_deadband,
//     right_deadband; write only while the block is idle.
// Throughput: one request per cycle while req_stall is low, encoder samples
//   and drive requests alike; encoder counts update in the accepting cycle.
// Path: an accepted drive request passes through the queue, the
//   scale/product stage, the divide stage and the output register.
// Stall: rsp_stall freezes the back pipeline; the 4-entry drive queue then
//   fills and req_stall rises only when it is full. Encoder samples are
//   held off only by a full queue.
// Reset: synchronous; counts, stored A levels, registers, queue and
//   pipeline valid bits clear. No output is valid after reset.
// ---------------------------------------------------------------------------
module differential_motor_drive_encoder_sync_unit
   import dmes_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_mode,
   input  logic                     req_left_a,
   input  logic                     req_left_b,
   input  logic                     req_right_a,
   input  logic                     req_right_b,
   input  logic signed [VOLT_W-1:0] req_voltage,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_left_reverse,
   output logic [DUTY_W-1:0]        rsp_left_duty,
   output logic                     rsp_right_reverse,
   output logic [DUTY_W-1:0]        rsp_right_duty,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    push, pop;
   cmd_type push_data, head;
   logic    queue_empty, queue_full;

   // register file; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_OFFSET_GAIN:    cfg_in.offset_gain    = csr_wdata;
            REG_LEFT_DEADBAND:  cfg_in.left_deadband  = csr_wdata;
            REG_RIGHT_DEADBAND: cfg_in.right_deadband = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: encoder tracking and drive request capture
   dmes_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_left_a  (req_left_a),
      .req_left_b  (req_left_b),
      .req_right_a (req_right_a),
      .req_right_b (req_right_b),
      .req_voltage (req_voltage),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data)
   );

   // decoupling queue
   dmes_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   // back: drive arithmetic and response register
   dmes_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .head              (head),
      .queue_empty       (queue_empty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_reverse  (rsp_left_reverse),
      .rsp_left_duty     (rsp_left_duty),
      .rsp_right_reverse (rsp_right_reverse),
      .rsp_right_duty    (rsp_right_duty)
   );

endmodule
